[design/cal_pkg.sv]
// Shared types and codes for the compacting array list.
package cal_pkg;

  typedef enum logic [2:0] {
    REQ_APPEND     = 3'd0,
    REQ_OVERWRITE  = 3'd1,
    REQ_READ       = 3'd2,
    REQ_REMOVE_IDX = 3'd3,
    REQ_REMOVE_VAL = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_IDX  = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SHIFT = 1'b1
  } state_e;

  // Broadcast controls seen by every cell of the chain.
  typedef struct packed {
    logic append;
    logic overwrite;
    logic shift_pos;
    logic shift_found;
  } cell_ctrl_t;

endpackage

[design/cal_req_if.sv]
// Request channel: valid/ready handshake carrying one list request.
interface cal_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] value;
  logic [5:0]         position;

  modport source (output valid, req_type, value, position, input ready);
  modport sink (input valid, req_type, value, position, output ready);
endinterface

[design/cal_rsp_if.sv]
// Response channel: valid/ready handshake carrying one request result.
interface cal_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [6:0]         entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink (input valid, status, read_value, entry_count, output ready);
endinterface

[design/cal_cell.sv]
// One list slot: holds a word, writes, shifts down from its upper neighbor, compares.
module cal_cell #(
  parameter int WIDTH = 32,
  parameter int IDX   = 0,
  parameter int CNTW  = 7,
  parameter int PW    = 7
) (
  input  logic                clk,
  input  cal_pkg::cell_ctrl_t ctrl,
  input  logic [PW-1:0]       pos,
  input  logic [CNTW-1:0]     count,
  input  logic [WIDTH-1:0]    val,
  input  logic [WIDTH-1:0]    upper,
  input  logic                ge,
  output logic [WIDTH-1:0]    word,
  output logic [WIDTH-1:0]    rd_word,
  output logic                eq
);

  localparam logic [PW-1:0]   MY_POS = PW'(IDX);
  localparam logic [CNTW-1:0] MY_CNT = CNTW'(IDX);

  always_ff @(posedge clk) begin
    if ((ctrl.append && count == MY_CNT) || (ctrl.overwrite && pos == MY_POS)) begin
      word <= val;
    end else if ((ctrl.shift_pos && pos <= MY_POS) || (ctrl.shift_found && ge)) begin
      // close the gap: take the word from the slot above
      word <= upper;
    end
  end

  assign rd_word = (pos == MY_POS) ? word : '0;
  assign eq      = (word == val) && (MY_CNT < count);

endmodule

[design/compacting_array_list_core.sv]
// Top level of the compacting array list: control, count and the chain of cells.
//
//   port   | dir | handshake      | carries
//   -------+-----+----------------+------------------------------------
//   req    | in  | valid/ready    | req_type, value, position
//   rsp    | out | valid/ready    | status, read_value, entry_count
//   cfg_*  | in  | write enable   | capacity_in_use (7 bits)
//
// Every request but remove value finishes in the cycle it is accepted; its
// result is registered and shows on rsp in the following cycle. Remove value
// adds a shift state: the cells compare in the accept cycle, then the first
// hit is picked from the registered match mask and the later cells shift down.
// rst clears the count and sets the capacity to 64 (or DEPTH if smaller).
// Requests are taken only in idle, with the result register empty or draining.
module compacting_array_list_core #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  cal_req_if.sink      req,
  cal_rsp_if.source    rsp
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int PW   = (CNTW > 6) ? CNTW : 6;
  localparam int XW   = (CNTW > 7) ? CNTW : 7;
  localparam logic [CNTW-1:0] CAP_RST = CNTW'((DEPTH < 64) ? DEPTH : 64);

  cal_pkg::state_e     state, state_next;
  logic [CNTW-1:0]     count, count_next;
  logic [CNTW-1:0]     cap;
  logic [DEPTH-1:0]    eq_mask;
  logic                rsp_valid;
  cal_pkg::status_e    status, status_next;
  logic signed [31:0]  read_value, read_value_next;

  cal_pkg::cell_ctrl_t ctrl;
  logic [WIDTH-1:0]    words [DEPTH];
  logic [WIDTH-1:0]    rd_words [DEPTH];
  logic [DEPTH-1:0]    eq;
  logic [DEPTH-1:0]    below, ge_mask;
  logic [WIDTH-1:0]    val_w, rd_or;
  logic [WIDTH+31:0]   val_ext, rd_ext;
  logic [PW-1:0]       pos_x;
  logic [XW-1:0]       cfg_x, cap_new;
  logic                accept, pos_ok, full, found, load_rsp;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == cal_pkg::ST_IDLE) && (!rsp_valid || rsp.ready);

  assign val_ext = {WIDTH'(0), req.value};
  assign val_w   = val_ext[WIDTH-1:0];
  assign pos_x   = PW'(req.position);
  assign pos_ok  = pos_x < PW'(count);
  assign full    = count >= cap;
  assign found   = |eq_mask;

  // ones below the first hit; the hit and every slot above it shift
  assign below   = (eq_mask - DEPTH'(1)) & ~eq_mask;
  assign ge_mask = ~below;

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | rd_words[i];
    end
  end
  assign rd_ext = {{32{rd_or[WIDTH-1]}}, rd_or};

  always_comb begin
    state_next      = state;
    count_next      = count;
    status_next     = cal_pkg::STAT_OK;
    read_value_next = '0;
    load_rsp        = 1'b0;
    ctrl            = '0;
    unique case (state)
      cal_pkg::ST_IDLE: begin
        if (accept) begin
          load_rsp = 1'b1;
          case (cal_pkg::req_e'(req.req_type))
            cal_pkg::REQ_APPEND: begin
              if (full) begin
                status_next = cal_pkg::STAT_FULL;
              end else begin
                ctrl.append = 1'b1;
                count_next  = count + CNTW'(1);
              end
            end
            cal_pkg::REQ_OVERWRITE: begin
              if (pos_ok) ctrl.overwrite = 1'b1;
              else status_next = cal_pkg::STAT_BAD_IDX;
            end
            cal_pkg::REQ_READ: begin
              if (pos_ok) read_value_next = rd_ext[31:0];
              else status_next = cal_pkg::STAT_BAD_IDX;
            end
            cal_pkg::REQ_REMOVE_IDX: begin
              if (pos_ok) begin
                ctrl.shift_pos = 1'b1;
                count_next     = count - CNTW'(1);
              end else begin
                status_next = cal_pkg::STAT_BAD_IDX;
              end
            end
            cal_pkg::REQ_REMOVE_VAL: begin
              // hold the result until the shift cycle
              load_rsp   = 1'b0;
              state_next = cal_pkg::ST_SHIFT;
            end
            cal_pkg::REQ_CLEAR: count_next = '0;
            default: ;
          endcase
        end
      end
      cal_pkg::ST_SHIFT: begin
        load_rsp   = 1'b1;
        state_next = cal_pkg::ST_IDLE;
        if (found) begin
          ctrl.shift_found = 1'b1;
          count_next       = count - CNTW'(1);
        end else begin
          status_next = cal_pkg::STAT_NOT_FOUND;
        end
      end
      default: state_next = cal_pkg::ST_IDLE;
    endcase
  end

  assign cfg_x   = XW'(cfg_wdata);
  assign cap_new = (cfg_x > XW'(DEPTH)) ? XW'(DEPTH) : cfg_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cal_pkg::ST_IDLE;
      count     <= '0;
      cap       <= CAP_RST;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cap <= CNTW'(cap_new);
        if (XW'(count) > cap_new) count <= CNTW'(cap_new);
      end else begin
        count <= count_next;
      end
      if (load_rsp) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) eq_mask <= eq;
    if (load_rsp) begin
      status     <= status_next;
      read_value <= read_value_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = status;
  assign rsp.read_value  = read_value;
  assign rsp.entry_count = 7'(count);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] upper;
    if (i < DEPTH - 1) begin : g_mid
      assign upper = words[i+1];
    end else begin : g_last
      assign upper = words[i];
    end
    cal_cell #(
      .WIDTH (WIDTH),
      .IDX   (i),
      .CNTW  (CNTW),
      .PW    (PW)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .pos     (pos_x),
      .count   (count),
      .val     (val_w),
      .upper   (upper),
      .ge      (ge_mask[i]),
      .word    (words[i]),
      .rd_word (rd_words[i]),
      .eq      (eq[i])
    );
  end

endmodule

[sim/cal_list_checker.sv]
// Checker for the compacting array list: predicts each request's result and compares.
`timescale 1ns / 1ps
module cal_list_checker
  import cal_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  cal_req_if         req_mon,
  cal_rsp_if         rsp_mon,
  output int         fail_count,
  output int         outstanding
);

  localparam int LIST_DEPTH = 64;
  localparam int SHOWN_MAX  = 10;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
  } list_result_t;

  logic signed [31:0] words [LIST_DEPTH];
  int                 live;
  int                 cap_limit;
  list_result_t       result_q [$];

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= SHOWN_MAX) $display("[%0t] %s", $realtime, msg);
  endtask

  // Delete one entry and shift the later ones down.
  task automatic drop_entry(input int at);
    for (int i = at; i < live - 1; i++) words[i] = words[i + 1];
    live--;
  endtask

  task automatic apply_request(input logic [2:0] kind, input logic signed [31:0] word,
                               input logic [5:0] idx, output list_result_t r);
    int hit;
    r.status     = STAT_OK;
    r.read_value = '0;
    case (kind)
      REQ_APPEND: begin
        if (live >= cap_limit) r.status = STAT_FULL;
        else begin
          words[live] = word;
          live++;
        end
      end
      REQ_OVERWRITE: begin
        if (int'(idx) >= live) r.status = STAT_BAD_IDX;
        else words[idx] = word;
      end
      REQ_READ: begin
        if (int'(idx) >= live) r.status = STAT_BAD_IDX;
        else r.read_value = words[idx];
      end
      REQ_REMOVE_IDX: begin
        if (int'(idx) >= live) r.status = STAT_BAD_IDX;
        else drop_entry(idx);
      end
      REQ_REMOVE_VAL: begin
        hit = -1;
        for (int i = 0; i < live; i++) if (hit < 0 && words[i] == word) hit = i;
        if (hit < 0) r.status = STAT_NOT_FOUND;
        else drop_entry(hit);
      end
      REQ_CLEAR: live = 0;
      default: ;
    endcase
    r.entry_count = 7'(live);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    list_result_t fresh;
    if (rst) begin
      live       = 0;
      cap_limit  = LIST_DEPTH;
      fail_count = 0;
      result_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        cap_limit = (int'(cfg_wdata) > LIST_DEPTH) ? LIST_DEPTH : int'(cfg_wdata);
        if (live > cap_limit) live = cap_limit;
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (result_q.size() == 0) begin
          note_failure($sformatf("unexpected response: status %0d read_value %0d count %0d",
                                 rsp_mon.status, rsp_mon.read_value, rsp_mon.entry_count));
        end else begin
          want = result_q.pop_front();
          if (rsp_mon.status !== want.status || rsp_mon.read_value !== want.read_value ||
              rsp_mon.entry_count !== want.entry_count)
            note_failure($sformatf({"mismatch: expected status %0d read_value %0d count %0d",
                                    ", got status %0d read_value %0d count %0d"},
                                   want.status, want.read_value, want.entry_count,
                                   rsp_mon.status, rsp_mon.read_value,
                                   rsp_mon.entry_count));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        apply_request(req_mon.req_type, req_mon.value, req_mon.position, fresh);
        result_q.push_back(fresh);
      end
      outstanding <= result_q.size();
    end
  end

endmodule

[sim/tb.sv]
// Testbench top for the compacting array list: drives requests, response stalls and capacity.
`timescale 1ns / 1ps
module tb;
  import cal_pkg::*;

  localparam int PHASE_ITEMS  = 90;
  localparam int PHASE_COUNT  = 8;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 500000;

  // Spare request codes: the block treats them as no-ops.
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [6:0] cfg_wdata;
  int         fail_count;
  int         outstanding;
  int         cycle_count = 0;
  bit         req_up = 1'b0;
  bit         steady = 1'b0;
  bit         hold_pending = 1'b0;
  logic [6:0] caps [PHASE_COUNT] = '{7'd64, 7'd1, 7'd127, 7'd17, 7'd0, 7'd2, 7'd100, 7'd40};

  cal_req_if req_ch ();
  cal_rsp_if rsp_ch ();

  compacting_array_list_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  cal_list_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none while steady.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [2:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 36) return REQ_APPEND;
    if (r < 48) return REQ_OVERWRITE;
    if (r < 66) return REQ_READ;
    if (r < 78) return REQ_REMOVE_IDX;
    if (r < 93) return REQ_REMOVE_VAL;
    if (r < 96) return REQ_CLEAR;
    if (r < 98) return REQ_SPARE_6;
    return REQ_SPARE_7;
  endfunction

  // Small words repeat often so that remove by value finds hits and duplicates.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -32'sd1;
      4, 5, 6: return 32'($urandom_range(0, 15)) - 32'sd8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [5:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 6'($urandom_range(0, 7));
    if (r < 9) return 6'($urandom_range(0, 31));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic send_req(input logic [2:0] kind, input logic signed [31:0] word,
                          input logic [5:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0 && req_up) begin
      req_ch.valid <= 1'b0;
      req_up = 1'b0;
    end
    repeat (gap) @(posedge clk);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value    <= word;
    req_ch.position <= idx;
    req_up = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic req_idle();
    if (req_up) begin
      req_ch.valid <= 1'b0;
      req_up = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_idle();
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] cap);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Response side: random stalls, ready stretches, and one long hold on request.
  initial begin
    int stall;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_APPEND;
    req_ch.value    <= '0;
    req_ch.position <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tiny capacity to reach full, then every operation and error case.
    write_capacity(7'd3);
    send_req(REQ_APPEND, WORD_MIN, 6'd0);
    send_req(REQ_APPEND, WORD_MAX, 6'd0);
    send_req(REQ_APPEND, '0, 6'd0);
    send_req(REQ_APPEND, 32'sd5, 6'd0);
    send_req(REQ_READ, '0, 6'd0);
    send_req(REQ_READ, '0, 6'd2);
    send_req(REQ_READ, '0, 6'd3);
    send_req(REQ_READ, '0, 6'd63);
    send_req(REQ_OVERWRITE, -32'sd1, 6'd1);
    send_req(REQ_OVERWRITE, 32'sd9, 6'd3);
    send_req(REQ_READ, '0, 6'd1);
    send_req(REQ_REMOVE_VAL, 32'sh1234_5678, 6'd0);
    send_req(REQ_REMOVE_VAL, -32'sd1, 6'd0);
    send_req(REQ_REMOVE_IDX, '0, 6'd5);
    send_req(REQ_REMOVE_IDX, '0, 6'd0);
    send_req(REQ_SPARE_6, WORD_MAX, 6'd63);
    send_req(REQ_SPARE_7, WORD_MIN, 6'd0);
    send_req(REQ_APPEND, WORD_MIN, 6'd0);
    send_req(REQ_REMOVE_VAL, WORD_MIN, 6'd0);
    send_req(REQ_CLEAR, '0, 6'd0);
    send_req(REQ_READ, '0, 6'd0);
    send_req(REQ_REMOVE_VAL, '0, 6'd0);
    send_req(REQ_REMOVE_IDX, '0, 6'd0);
    send_req(REQ_OVERWRITE, '0, 6'd0);
    send_req(REQ_APPEND, 32'sd7, 6'd0);
    // Zero capacity clips the count and blocks every append.
    write_capacity(7'd0);
    send_req(REQ_APPEND, 32'sd11, 6'd0);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_capacity(caps[ph]);
      steady = (ph == 6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 20) hold_pending = 1'b1;
        if (ph == 3 && n == 45) wait_drained();
        send_req(pick_kind(), pick_word(), pick_index());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
design/cal_pkg.sv
design/cal_req_if.sv
design/cal_rsp_if.sv
design/cal_cell.sv
design/compacting_array_list_core.sv
sim/cal_list_checker.sv
sim/tb.sv
